[rtl/acet_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the AABB contact event tracker.
// No dependencies; imported by the tracker, its contact memory and its checker.
package acet_pkg;

	// Fixed field widths
	localparam int ID_W    = 6;
	localparam int COORD_W = 16;

	// Contact event codes
	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} ev_t;

endpackage

[rtl/aabb_contact_event_tracker.sv]
`timescale 1ns / 1ps
// AABB overlap test with per-pair enter/stay/exit contact tracking.
// Depends on acet_pkg and acet_contact_mem.
//
// Takes one collider pair per cycle while in_stall is low and returns one
// transaction per pair through the stage 1 and output registers. The contact
// bits sit in a row-wide memory (one row per left collider) with a registered
// read; each pair reads its row on acceptance and writes it back as it leaves
// stage 1, with the last write forwarded so back-to-back pairs on the same row
// see fresh data. After reset the block clears the memory one row per cycle
// and holds in_stall high until every row is clear. Self pairs and ids at or
// above COLLIDER_COUNT report no event and leave the contact bits untouched.
module aabb_contact_event_tracker import acet_pkg::*; #(
	parameter int COLLIDER_COUNT = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [ID_W-1:0]           left_id,
	input  logic [ID_W-1:0]           peer_id,
	input  logic signed [COORD_W-1:0] left_x,
	input  logic signed [COORD_W-1:0] left_y,
	input  logic [COORD_W-1:0]        left_w,
	input  logic [COORD_W-1:0]        left_h,
	input  logic signed [COORD_W-1:0] right_x,
	input  logic signed [COORD_W-1:0] right_y,
	input  logic [COORD_W-1:0]        right_w,
	input  logic [COORD_W-1:0]        right_h,
	input  logic                      left_dying,
	input  logic                      right_dying,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                contact_event,
	output logic                      overlapping
);

	// Ids are 6 bits wide, so at most 64 colliders are reachable
	localparam int ID_SPAN = 1 << ID_W;
	localparam int ROWS    = (COLLIDER_COUNT < ID_SPAN) ? COLLIDER_COUNT : ID_SPAN;
	localparam int AW      = $clog2(ROWS);
	localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(ROWS);
	localparam int DW      = COORD_W + 1;

	logic                 accept;
	logic                 adv;
	logic                 mem_busy;
	logic                 pair_ok;

	// Stage 1 registers
	logic                 s1_valid_q;
	logic [AW-1:0]        lid_s1;
	logic [AW-1:0]        rid_s1;
	logic                 pair_ok_s1;
	logic                 dying_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic [DW-1:0]        sw_s1;
	logic [DW-1:0]        sh_s1;

	// Output register
	logic                 out_valid_q;
	ev_t                  ev_q;
	logic                 ov_q;

	logic [ROWS-1:0]      row_data;
	logic [ROWS-1:0]      row_next;
	logic [DW-1:0]        adx;
	logic [DW-1:0]        ady;
	logic                 ov;
	logic                 prev_bit;
	logic                 new_bit;
	ev_t                  ev;

	assign adv      = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = mem_busy || (s1_valid_q && !adv);
	assign accept   = in_valid && !in_stall;
	assign pair_ok  = (left_id != peer_id) && ({1'b0, left_id} < ID_LIMIT) &&
	                  ({1'b0, peer_id} < ID_LIMIT);

	// Stage 1: centre distances and size sums, row read issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lid_s1     <= left_id[AW-1:0];
			rid_s1     <= peer_id[AW-1:0];
			pair_ok_s1 <= pair_ok;
			dying_s1   <= left_dying | right_dying;
			dx_s1      <= DW'(right_x) - DW'(left_x);
			dy_s1      <= DW'(right_y) - DW'(left_y);
			sw_s1      <= {1'b0, left_w} + {1'b0, right_w};
			sh_s1      <= {1'b0, left_h} + {1'b0, right_h};
		end
	end

	acet_contact_mem #(
		.ROWS (ROWS),
		.AW   (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_row  (left_id[AW-1:0]),
		.rd_data (row_data),
		.wr_en   (adv && pair_ok_s1),
		.wr_row  (lid_s1),
		.wr_data (row_next),
		.busy    (mem_busy)
	);

	// Stage 2: overlap compare, event decision, row write-back
	always_comb begin
		adx      = dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
		ady      = dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
		ov       = ({adx, 1'b0} <= {1'b0, sw_s1}) && ({ady, 1'b0} <= {1'b0, sh_s1});
		prev_bit = row_data[rid_s1];
		new_bit  = ov && !dying_s1;
		row_next = row_data;
		row_next[rid_s1] = new_bit;
		if (!pair_ok_s1) begin
			ev = EV_NONE;
		end else begin
			unique case ({prev_bit, new_bit})
				2'b11:   ev = EV_STAY;
				2'b10:   ev = EV_EXIT;
				2'b01:   ev = EV_ENTER;
				default: ev = EV_NONE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q <= ev;
			ov_q <= ov;
		end
	end

	assign out_valid     = out_valid_q;
	assign contact_event = ev_q;
	assign overlapping   = ov_q;

endmodule

[rtl/acet_contact_mem.sv]
`timescale 1ns / 1ps
// Contact bit store: one row per left collider, one bit per right collider.
// Depends on acet_pkg. Holds the clear sweep after reset and write-to-read forwarding.
module acet_contact_mem import acet_pkg::*; #(
	parameter int ROWS = 64,
	parameter int AW   = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_row,
	output logic [ROWS-1:0] rd_data,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_row,
	input  logic [ROWS-1:0] wr_data,
	output logic            busy
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] rdata_q;
	logic [AW-1:0]   rd_row_q;
	logic            clearing_q;
	logic [AW-1:0]   clr_row_q;
	logic            fwd_valid_q;
	logic [AW-1:0]   fwd_row_q;
	logic [ROWS-1:0] fwd_data_q;

	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [ROWS-1:0] mem_wd;

	// Clear sweep owns the write port until every row is zero
	always_comb begin
		mem_we = clearing_q | wr_en;
		mem_wa = clearing_q ? clr_row_q : wr_row;
		mem_wd = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rdata_q  <= mem[rd_row];
			rd_row_q <= rd_row;
		end
	end

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			if (clr_row_q == AW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	// Last row written; covers a read issued on the same edge as the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en && !clearing_q) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !clearing_q) begin
			fwd_row_q  <= wr_row;
			fwd_data_q <= wr_data;
		end
	end

	assign rd_data = (fwd_valid_q && fwd_row_q == rd_row_q) ? fwd_data_q : rdata_q;
	assign busy    = clearing_q;

endmodule

[rtl/acet_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the AABB contact event tracker, bound to its top level.
// Depends on acet_pkg.
module acet_checker import acet_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] contact_event,
	input logic       overlapping
);

	// Without overlap a pair can only end a contact or report nothing
	a_no_overlap_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overlapping |-> (contact_event == EV_NONE || contact_event == EV_EXIT))
		else $error("enter or stay reported without overlap");

	// Enter and stay always come with overlapping boxes
	a_contact_needs_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (contact_event == EV_ENTER || contact_event == EV_STAY) |-> overlapping)
		else $error("contact event on non-overlapping boxes");

	// A new output transaction must trace back to an earlier accepted input pair
	a_out_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output transaction without a matching input transaction");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(contact_event) && $stable(overlapping))
		else $error("stalled output transaction changed");

endmodule

bind aabb_contact_event_tracker acet_checker u_acet_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.contact_event (contact_event),
	.overlapping   (overlapping)
);
